// ===== src/ltc_pkg.sv =====
// Shared types and constants of the lexeme token classifier.
package ltc_pkg;

   typedef enum logic [2:0] {
      CLS_OPERATOR = 3'd0,
      CLS_KEYWORD  = 3'd1,
      CLS_IDENT    = 3'd2,
      CLS_INTEGER  = 3'd3,
      CLS_FLOAT    = 3'd4,
      CLS_NONE     = 3'd5
   } token_class_type;

   typedef struct packed {
      logic            close;
      token_class_type token_class;
      logic [5:0]      lexeme_length;
      logic            line_done;
   } lexeme_close_type;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_STAR  = 8'h2a;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;
   localparam logic [7:0] CHAR_CARET = 8'h5e;
   localparam logic [7:0] CHAR_EQUAL = 8'h3d;

   localparam int KW_COUNT   = 22;
   localparam int KW_MAX_LEN = 8;

   typedef logic [8*KW_MAX_LEN-1:0] kw_text_type;
   typedef logic [3:0]              kw_len_type;

   // Words left-justified: first character in the top byte, NUL padded.
   localparam kw_text_type KW_TEXT [KW_COUNT] = '{
      {"if",       48'h0},
      {"else",     32'h0},
      {"while",    24'h0},
      {"do",       48'h0},
      {"break",    24'h0},
      {"continue"       },
      {"int",      40'h0},
      {"double",   16'h0},
      {"float",    24'h0},
      {"return",   16'h0},
      {"char",     32'h0},
      {"case",     32'h0},
      {"sizeof",   16'h0},
      {"long",     32'h0},
      {"short",    24'h0},
      {"typedef",   8'h0},
      {"switch",   16'h0},
      {"unsigned"       },
      {"void",     32'h0},
      {"static",   16'h0},
      {"struct",   16'h0},
      {"goto",     32'h0}
   };

   localparam kw_len_type KW_LEN [KW_COUNT] = '{
      4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd8, 4'd3, 4'd6, 4'd5, 4'd6, 4'd4,
      4'd4, 4'd6, 4'd4, 4'd5, 4'd7, 4'd6, 4'd8, 4'd4, 4'd6, 4'd6, 4'd4
   };

endpackage

// ===== src/ltc_keyword_match.sv =====
// Keyword table compare against the buffered lexeme prefix.
module ltc_keyword_match #(
   parameter int CW = 6
) (
   input  logic [7:0]    chars [8],
   input  logic [CW-1:0] count,
   output logic          hit
);
   import ltc_pkg::*;

   logic [KW_COUNT-1:0] word_hit;

   always_comb begin
      for (int k = 0; k < KW_COUNT; k++) begin
         word_hit[k] = (count == CW'(KW_LEN[k]));
         for (int i = 0; i < KW_MAX_LEN; i++) begin
            if (chars[i] != KW_TEXT[k][8*(KW_MAX_LEN-i)-1 -: 8]) begin
               word_hit[k] = 1'b0;
            end
         end
      end
      hit = |word_hit;
   end

endmodule

// ===== src/ltc_lexeme_track.sv =====
// Lexeme state registers, next-state logic and class decision.
module ltc_lexeme_track #(
   parameter int KBL  = 8,
   parameter int MAXL = 63
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [7:0]               char_byte,
   input  logic                     end_of_line,
   output ltc_pkg::lexeme_close_type close_info
);
   import ltc_pkg::*;

   localparam int CW = $clog2(MAXL + 1);

   logic [7:0]    prefix_ff [KBL];
   logic [7:0]    prefix_in [KBL];
   logic [7:0]    prefix_upd [KBL];
   logic [7:0]    kw_chars [8];
   logic [CW-1:0] cnt_ff, cnt_in, cnt_upd;
   logic          first_ff, first_in, first_upd;
   logic          all_ff, all_in, all_upd;
   logic          dod_ff, dod_in, dod_upd;
   logic          dot_ff, dot_in, dot_upd;
   logic          non_space, is_dig, is_dot, is_op, kw_hit, close;
   token_class_type cls;

   always_comb begin
      non_space = (char_byte != CHAR_SPACE);
      is_dig    = char_byte inside {[CHAR_ZERO:CHAR_NINE]};
      is_dot    = (char_byte == CHAR_DOT);
      for (int i = 0; i < KBL; i++) begin
         prefix_upd[i] = (non_space && cnt_ff == CW'(i)) ? char_byte : prefix_ff[i];
      end
      for (int i = 0; i < 8; i++) begin
         kw_chars[i] = prefix_upd[i];
      end
      cnt_upd   = (non_space && cnt_ff != CW'(MAXL)) ? cnt_ff + 1'b1 : cnt_ff;
      first_upd = (non_space && cnt_ff == '0) ? is_dig : first_ff;
      all_upd   = all_ff & (!non_space | is_dig);
      dod_upd   = dod_ff & (!non_space | is_dig | is_dot);
      dot_upd   = dot_ff | is_dot;
      close     = (!non_space || end_of_line) && (cnt_upd != '0);
      is_op     = prefix_upd[0] inside {CHAR_PLUS, CHAR_MINUS, CHAR_STAR,
                                        CHAR_SLASH, CHAR_CARET, CHAR_EQUAL};
      if (cnt_upd == CW'(1) && is_op) begin
         cls = CLS_OPERATOR;
      end else if (kw_hit) begin
         cls = CLS_KEYWORD;
      end else if (!first_upd) begin
         cls = CLS_IDENT;
      end else if (all_upd) begin
         cls = CLS_INTEGER;
      end else if (dod_upd && dot_upd) begin
         cls = CLS_FLOAT;
      end else begin
         cls = CLS_NONE;
      end
      close_info.close         = close;
      close_info.token_class   = cls;
      close_info.lexeme_length = 6'(cnt_upd);
      close_info.line_done     = end_of_line;

      // drop the lexeme once it closes
      for (int i = 0; i < KBL; i++) begin
         prefix_in[i] = close ? 8'h00 : prefix_upd[i];
      end
      cnt_in   = close ? '0 : cnt_upd;
      first_in = close ? 1'b0 : first_upd;
      all_in   = close ? 1'b1 : all_upd;
      dod_in   = close ? 1'b1 : dod_upd;
      dot_in   = close ? 1'b0 : dot_upd;
   end

   ltc_keyword_match #(.CW(CW)) u_keyword (
      .chars (kw_chars),
      .count (cnt_upd),
      .hit   (kw_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KBL; i++) begin
            prefix_ff[i] <= 8'h00;
         end
         cnt_ff   <= '0;
         first_ff <= 1'b0;
         all_ff   <= 1'b1;
         dod_ff   <= 1'b1;
         dot_ff   <= 1'b0;
      end else if (advance) begin
         prefix_ff <= prefix_in;
         cnt_ff    <= cnt_in;
         first_ff  <= first_in;
         all_ff    <= all_in;
         dod_ff    <= dod_in;
         dot_ff    <= dot_in;
      end
   end

endmodule

// ===== src/lexeme_token_classifier.sv =====
// Top level of the lexeme token classifier with request and result registers.
//
// Usage: characters of a text line arrive on the req_ channel, one per
// request; req_tdata is the character code and req_tlast marks the last
// character of the line. Space characters separate lexemes. For every
// lexeme closed by a space or by req_tlast one result leaves on the rsp_
// channel: rsp_tuser is the token class, rsp_tdata the saturated lexeme
// length and rsp_tlast flags the last lexeme of the line.
// Path: an accepted request is held in the request register, classified
// combinationally, and its result is captured in the result register,
// which drives rsp_tvalid.
// Throughput: one character per cycle unless a closing character stalls;
// set by the single classify stage between the request and result registers.
// Stall: while a result waits on rsp_tready the request register keeps
// taking characters that do not close a lexeme; a character that closes a
// lexeme holds in it, with req_tready low, until the result register frees.
// Reset: clears both valid flags and the open lexeme; no result is pending.
module lexeme_token_classifier #(
   parameter int KEYWORD_BUFFER_LEN = 8,
   parameter int MAX_LEXEME_LEN     = 63
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_byte
   input  logic       req_tlast,   // end_of_line
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [5:0] lexeme_length, [7:6] zero
   output logic [2:0] rsp_tuser,   // [2:0] token_class
   output logic       rsp_tlast    // line_done
);
   import ltc_pkg::*;

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_char_ff;
   logic             in_eol_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   token_class_type  rsp_class_ff;
   logic [5:0]       rsp_len_ff;
   logic             rsp_last_ff;
   logic             out_free, advance, load_req, load_rsp;
   lexeme_close_type close_info;

   ltc_lexeme_track #(
      .KBL  (KEYWORD_BUFFER_LEN),
      .MAXL (MAX_LEXEME_LEN)
   ) u_track (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .char_byte   (in_char_ff),
      .end_of_line (in_eol_ff),
      .close_info  (close_info)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      advance      = in_valid_ff && (!close_info.close || out_free);
      req_tready   = !in_valid_ff || advance;
      load_req     = req_tvalid && req_tready;
      load_rsp     = advance && close_info.close;
      in_valid_in  = load_req || (in_valid_ff && !advance);
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_req) begin
         in_char_ff <= req_tdata;
         in_eol_ff  <= req_tlast;
      end
      if (load_rsp) begin
         rsp_class_ff <= close_info.token_class;
         rsp_len_ff   <= close_info.lexeme_length;
         rsp_last_ff  <= close_info.line_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_len_ff};
   assign rsp_tuser  = rsp_class_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff && !in_valid_ff)
      else $error("registers not empty after reset");

   a_request_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_char_ff) && $stable(in_eol_ff))
      else $error("held request lost or changed");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance) && $past(close_info.close))
      else $error("result without a closing request");

   a_operator_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_class_ff == CLS_OPERATOR |-> rsp_len_ff == 6'd1)
      else $error("operator lexeme longer than one character");

endmodule
